FILE: rtl/cdsd_pkg.sv
// ----------------------------------------------------------------------------
// Calendar date to serial day: shared types and constants
// Field widths, calendar constants and the month tables used by the decode
// and conversion logic.
// ----------------------------------------------------------------------------
`default_nettype none

package cdsd_pkg;

    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECOND_W  = 6;
    localparam int DNUM_W    = 23;
    localparam int SECS_W    = 17;
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 40;

    localparam int SERIAL_OFFSET    = 693959;
    localparam int MAX_YEAR         = 9999;
    localparam int PACKED_BASE_YEAR = 1989;
    localparam int DAYS_PER_YEAR    = 365;
    localparam int SECS_PER_HOUR    = 3600;
    localparam int SECS_PER_MINUTE  = 60;

    // floor(y / 100) == (y * DIV100_MUL) >> DIV100_SHIFT for every 14-bit y
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;

    // Source selector carried on the input tuser
    localparam logic CMD_FIELDS = 1'b0;
    localparam logic CMD_PACKED = 1'b1;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } date_fields_t;

    typedef struct packed {
        logic                     valid_res;
        logic signed [DNUM_W-1:0] day_number;
        logic [SECS_W-1:0]        seconds_of_day;
    } serial_res_t;

    // Days before the first of the month in a common year
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] mo);
        logic [8:0] d;
        unique case (mo)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Month length in a common year; zero for a month code outside 1 to 12
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mo);
        logic [DAY_W-1:0] n;
        unique case (mo)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
            4'd2:                                       n = 5'd28;
            default:                                    n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/calendar_date_to_serial_day.sv
// ----------------------------------------------------------------------------
// Calendar date to serial day
// Streaming converter from a Gregorian date and time to a serial day number
// and seconds into the day.
// ----------------------------------------------------------------------------
// Takes one date-time transaction per clock and returns one result for each,
// in order, while the output side is not stalled. A transaction is held in
// the input register and then in the result register, and the conversion
// between them is a single pass of short arithmetic; so, unless stalled, a new
// transaction is taken every cycle. A date is valid for years up to 9999,
// months 1 to 12, days within the month (leap years per the proleptic
// Gregorian rules, year 0 being leap), hours up to 23 and minutes and seconds
// up to 59. Invalid transactions return valid_res low with both numbers zero.
// Day 0 is 1899-12-30; forming a fractional day is left to the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_to_serial_day
    import cdsd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // [15:0] packed_date, [29:16] year, [33:30] month, [38:34] day,
    // [43:39] hour, [49:44] minute, [55:50] second
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // [0] command
    input  wire logic                s_tuser,

    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [22:0] day_number, [39:23] seconds_of_day
    output logic [M_DATA_W-1:0]      m_tdata,
    // [0] valid_res
    output logic                     m_tuser
);

    date_fields_t dec_fields;
    date_fields_t in_data_reg;
    logic         in_valid_reg;
    logic         in_valid_next;
    serial_res_t  calc_res;
    serial_res_t  out_res_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         advance;
    logic         s_accept;

    cdsd_decode u_decode (
        .cmd    (s_tuser),
        .data   (s_tdata),
        .fields (dec_fields)
    );

    cdsd_convert u_convert (
        .fields (in_data_reg),
        .res    (calc_res)
    );

    // Move the input stage on whenever the result register is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = in_valid_reg;
        end
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= dec_fields;
        end
        if (advance && in_valid_reg) begin
            out_res_reg <= calc_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.valid_res;
    assign m_tdata  = {out_res_reg.seconds_of_day, out_res_reg.day_number};

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("invalid result carries non-zero data");

    a_secs_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[39:23] < 17'd86400))
        else $error("seconds of day out of range");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with an empty result register");

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> in_valid_reg)
        else $error("accepted transaction not held in the input stage");
`endif

endmodule

`default_nettype wire

FILE: rtl/cdsd_decode.sv
// ----------------------------------------------------------------------------
// Calendar date to serial day: input decode
// Selects between the separate date/time fields and the packed 16-bit date,
// giving one set of calendar fields.
// ----------------------------------------------------------------------------
`default_nettype none

module cdsd_decode
    import cdsd_pkg::*;
(
    input  wire logic                cmd,
    input  wire logic [S_DATA_W-1:0] data,
    output date_fields_t             fields
);

    logic [15:0] packed_date;

    assign packed_date = data[15:0];

    always_comb begin
        unique case (cmd)
            CMD_PACKED: begin
                // A packed zero lands on month 0, which fails validation
                fields.day    = packed_date[4:0];
                fields.month  = packed_date[8:5];
                fields.year   = YEAR_W'(PACKED_BASE_YEAR) + YEAR_W'(packed_date[15:9]);
                fields.hour   = '0;
                fields.minute = '0;
                fields.second = '0;
            end
            default: begin
                fields.year   = data[29:16];
                fields.month  = data[33:30];
                fields.day    = data[38:34];
                fields.hour   = data[43:39];
                fields.minute = data[49:44];
                fields.second = data[55:50];
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/cdsd_convert.sv
// ----------------------------------------------------------------------------
// Calendar date to serial day: conversion
// Validates one set of calendar fields and works out the serial day number
// (day 0 is 1899-12-30) and the seconds into the day.
// ----------------------------------------------------------------------------
`default_nettype none

module cdsd_convert
    import cdsd_pkg::*;
(
    input  wire date_fields_t fields,
    output serial_res_t       res
);

    logic [26:0]       div_prod;
    logic [7:0]        cent;
    logic              cent_exact;
    logic              leap;
    logic [DAY_W-1:0]  mlen;
    logic              date_ok;
    logic              time_ok;
    logic [DNUM_W-1:0] dsum;
    logic [SECS_W-1:0] ssum;

    // Century count by reciprocal multiplication; four-century counts follow by shift
    assign div_prod   = 27'(fields.year) * 27'(DIV100_MUL);
    assign cent       = div_prod[26:DIV100_SHIFT];
    assign cent_exact = (15'(cent) * 15'd100) == 15'(fields.year);
    assign leap       = (fields.year[1:0] == 2'b00) && (!cent_exact || (cent[1:0] == 2'b00));

    assign mlen    = month_len(fields.month) + DAY_W'(leap && (fields.month == 4'd2));
    assign date_ok = (fields.year <= YEAR_W'(MAX_YEAR))
                  && (fields.month >= 4'd1) && (fields.month <= 4'd12)
                  && (fields.day >= 5'd1) && (fields.day <= mlen);
    assign time_ok = (fields.hour <= 5'd23) && (fields.minute <= 6'd59)
                  && (fields.second <= 6'd59);

    // Modulo 2^23 arithmetic; the true value fits the signed result for valid years
    assign dsum = DNUM_W'(fields.year) * DNUM_W'(DAYS_PER_YEAR)
                + DNUM_W'(fields.year[YEAR_W-1:2])
                - DNUM_W'(cent)
                + DNUM_W'(cent[7:2])
                + DNUM_W'(days_before(fields.month))
                + DNUM_W'(fields.day)
                - DNUM_W'(leap && (fields.month <= 4'd2))
                - DNUM_W'(SERIAL_OFFSET);

    assign ssum = SECS_W'(fields.hour) * SECS_W'(SECS_PER_HOUR)
                + SECS_W'(fields.minute) * SECS_W'(SECS_PER_MINUTE)
                + SECS_W'(fields.second);

    always_comb begin
        if (date_ok && time_ok) begin
            res.valid_res      = 1'b1;
            res.day_number     = dsum;
            res.seconds_of_day = ssum;
        end else begin
            res.valid_res      = 1'b0;
            res.day_number     = '0;
            res.seconds_of_day = '0;
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb_calendar_date_to_serial_day.sv
// ----------------------------------------------------------------------------
// Calendar date to serial day: testbench
// Streams date-time transactions through the converter and checks every
// result against a behavioural model of the Gregorian serial day count, with
// edge dates first, then random traffic under varying source and sink idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_calendar_date_to_serial_day;
    import cdsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic                command;
        logic [15:0]         packed_date;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } date_item_t;

    typedef struct {
        logic              valid_res;
        logic [DNUM_W-1:0] day_number;
        logic [SECS_W-1:0] seconds_of_day;
    } serial_day_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = CMD_FIELDS;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;

    serial_day_t pending_serials[$];
    int          send_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          mismatch_cnt = 0;
    int          dates_sent = 0;
    int          results_seen = 0;
    int          valid_seen = 0;
    int          cycle_cnt = 0;

    // Days before the first of each month in a common year, January first
    int month_start[13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};

    calendar_date_to_serial_day i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic bit leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // Zero for a month code outside 1 to 12
    function automatic int month_days(input int unsigned y, input int unsigned mo);
        if (mo < 1 || mo > 12) begin
            return 0;
        end
        return month_start[mo] - month_start[mo-1] + ((mo == 2 && leap_year(y)) ? 1 : 0);
    endfunction

    function automatic serial_day_t serial_of_date(input date_item_t it);
        serial_day_t  r;
        int unsigned  y, mo, d, h, mi, s;
        int           n;
        r = '{valid_res: 1'b0, day_number: '0, seconds_of_day: '0};
        if (it.command == CMD_PACKED) begin
            d  = 32'(it.packed_date[4:0]);
            mo = 32'(it.packed_date[8:5]);
            y  = (it.packed_date == 16'd0) ? 0 : 32'(it.packed_date[15:9]) + PACKED_BASE_YEAR;
            h  = 0;
            mi = 0;
            s  = 0;
        end else begin
            y  = 32'(it.year);
            mo = 32'(it.month);
            d  = 32'(it.day);
            h  = 32'(it.hour);
            mi = 32'(it.minute);
            s  = 32'(it.second);
        end
        if (y <= MAX_YEAR && d >= 1 && d <= month_days(y, mo) && h <= 23 && mi <= 59
                && s <= 59) begin
            n = y * 365 + y / 4 - y / 100 + y / 400 + month_start[mo-1] + d;
            // the leap day of this year is not yet behind us in January and February
            if (mo <= 2 && leap_year(y)) begin
                n = n - 1;
            end
            n = n - SERIAL_OFFSET;
            r.valid_res      = 1'b1;
            r.day_number     = n[DNUM_W-1:0];
            r.seconds_of_day = SECS_W'(h * 3600 + mi * 60 + s);
        end
        return r;
    endfunction

    function automatic date_item_t field_date(input int y, input int mo, input int d,
                                              input int h, input int mi, input int s);
        date_item_t it;
        it.command     = CMD_FIELDS;
        it.packed_date = 16'($urandom_range(16'hFFFF));
        it.year        = YEAR_W'(y);
        it.month       = MONTH_W'(mo);
        it.day         = DAY_W'(d);
        it.hour        = HOUR_W'(h);
        it.minute      = MINUTE_W'(mi);
        it.second      = SECOND_W'(s);
        return it;
    endfunction

    function automatic date_item_t packed_date_item(input int unsigned p);
        date_item_t it;
        it = field_date($urandom_range(16383), $urandom_range(15), $urandom_range(31),
                        $urandom_range(31), $urandom_range(63), $urandom_range(63));
        it.command     = CMD_PACKED;
        it.packed_date = 16'(p);
        return it;
    endfunction

    // Present one transaction, hold until taken, then idle at random
    task automatic send_date(input date_item_t it);
        s_tvalid <= 1'b1;
        s_tuser  <= it.command;
        s_tdata  <= {it.second, it.minute, it.hour, it.day, it.month, it.year,
                     it.packed_date};
        do @(posedge aclk); while (!s_tready);
        pending_serials.push_back(serial_of_date(it));
        dates_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    task automatic check_result();
        serial_day_t want;
        if (pending_serials.size() == 0) begin
            $error("result with nothing outstanding: tdata %h tuser %b", m_tdata, m_tuser);
            mismatch_cnt++;
        end else begin
            want = pending_serials.pop_front();
            if (m_tuser !== want.valid_res) begin
                $error("valid_res: expected %0d actual %0d", want.valid_res, m_tuser);
                mismatch_cnt++;
            end
            if (m_tdata[DNUM_W-1:0] !== want.day_number) begin
                $error("day_number: expected %0d actual %0d", $signed(want.day_number),
                       $signed(m_tdata[DNUM_W-1:0]));
                mismatch_cnt++;
            end
            if (m_tdata[DNUM_W+SECS_W-1:DNUM_W] !== want.seconds_of_day) begin
                $error("seconds_of_day: expected %0d actual %0d", want.seconds_of_day,
                       m_tdata[DNUM_W+SECS_W-1:DNUM_W]);
                mismatch_cnt++;
            end
            if (want.valid_res) begin
                valid_seen++;
            end
        end
        results_seen++;
    endtask

    // Sink: check each accepted result, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_result();
        end
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_serials.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic test_field_edges();
        send_date(field_date(1899, 12, 30, 0, 0, 0));
        send_date(field_date(1899, 12, 29, 0, 0, 1));
        send_date(field_date(0, 1, 1, 0, 0, 0));
        send_date(field_date(0, 2, 29, 12, 30, 30));
        send_date(field_date(9999, 12, 31, 23, 59, 59));
        send_date(field_date(10000, 1, 1, 0, 0, 0));
        send_date(field_date(16383, 15, 31, 31, 63, 63));
        send_date(field_date(2000, 0, 1, 0, 0, 0));
        send_date(field_date(2000, 13, 1, 0, 0, 0));
        send_date(field_date(2000, 4, 0, 0, 0, 0));
        send_date(field_date(2000, 4, 31, 0, 0, 0));
        send_date(field_date(1900, 2, 29, 0, 0, 0));
        send_date(field_date(2000, 2, 29, 0, 0, 0));
        send_date(field_date(2023, 2, 29, 0, 0, 0));
        send_date(field_date(2024, 3, 1, 24, 0, 0));
        send_date(field_date(2024, 3, 1, 0, 60, 0));
        send_date(field_date(2024, 3, 1, 0, 0, 60));
    endtask

    task automatic test_packed_edges();
        send_date(packed_date_item(16'h0000));
        send_date(packed_date_item(16'hFFFF));
        send_date(packed_date_item((127 << 9) | (12 << 5) | 31));
        send_date(packed_date_item((0 << 9) | (1 << 5) | 1));
        send_date(packed_date_item((11 << 9) | (2 << 5) | 29));
        send_date(packed_date_item((5 << 9) | (0 << 5) | 7));
        send_date(packed_date_item((5 << 9) | (6 << 5) | 0));
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        date_item_t it;
        int         y, mo, d;
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (n_items) begin
            if ($urandom_range(99) < 25) begin
                // packed: mostly plausible months, sometimes raw noise
                if ($urandom_range(99) < 70) begin
                    it = packed_date_item(($urandom_range(127) << 9)
                                          | ($urandom_range(1, 12) << 5)
                                          | $urandom_range(31));
                end else begin
                    it = packed_date_item($urandom_range(16'hFFFF));
                end
            end else if ($urandom_range(99) < 70) begin
                case ($urandom_range(9))
                    0:       y = $urandom_range(400);
                    1:       y = $urandom_range(9600, MAX_YEAR);
                    2:       y = $urandom_range(1899, 1901);
                    default: y = $urandom_range(MAX_YEAR);
                endcase
                mo = $urandom_range(1, 12);
                d  = ($urandom_range(99) < 30) ? month_days(y, mo)
                                               : $urandom_range(1, month_days(y, mo));
                it = field_date(y, mo, d, $urandom_range(23), $urandom_range(59),
                                $urandom_range(59));
            end else begin
                it = field_date($urandom_range(16383), $urandom_range(15), $urandom_range(31),
                                $urandom_range(31), $urandom_range(63), $urandom_range(63));
            end
            send_date(it);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_field_edges();
        test_packed_edges();
        test_random_traffic(480, 0, 0);
        test_random_traffic(480, 45, 0);
        test_random_traffic(480, 0, 45);
        test_random_traffic(480, 25, 25);

        s_tvalid <= 1'b0;
        while (pending_serials.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d dates sent, %0d results checked, %0d of them valid", dates_sent,
                 results_seen, valid_seen);
        $display("covered edge dates, packed decode and random traffic under back-pressure");
        if (mismatch_cnt == 0 && pending_serials.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: calendar_date_to_serial_day.f
rtl/cdsd_pkg.sv
rtl/cdsd_decode.sv
rtl/cdsd_convert.sv
rtl/calendar_date_to_serial_day.sv
tb/tb_calendar_date_to_serial_day.sv
